[hdl/pim_pkg.sv]
// Shared types and constants for the posture and inactivity monitor.
// No dependencies; imported by pim_activity and the top level.
`default_nettype none

package pim_pkg;

  localparam int ACCEL_W = 15;  // sample field width, signed milli-g
  localparam int THR_W   = 14;  // posture threshold width
  localparam int CNT_W   = 16;  // still / episode counters, motion and limit regs
  localparam int SUM_W   = 17;  // |x|+|y|+|z| before saturation

  typedef enum logic [2:0] {
    POS_PRONE  = 3'd0,
    POS_SUPINE = 3'd1,
    POS_LEFT   = 3'd2,
    POS_RIGHT  = 3'd3,
    POS_MIDDLE = 3'd4
  } posture_t;

  typedef enum logic [1:0] {
    BUZ_SILENT = 2'd0,
    BUZ_PRONE  = 2'd1,
    BUZ_APNEA  = 2'd2
  } buzzer_t;

  typedef enum logic [1:0] {
    CFG_POSTURE_THR = 2'd0,
    CFG_MOTION_THR  = 2'd1,
    CFG_STILL_LIMIT = 2'd2
  } cfg_idx_t;

  // Result of one sample as seen by the activity tracker.
  typedef struct packed {
    logic             moved;
    logic             apnea;
    logic [CNT_W-1:0] episodes;
  } activity_t;

  function automatic logic [ACCEL_W-1:0] abs_accel(input logic signed [ACCEL_W-1:0] v);
    logic [ACCEL_W-1:0] r;
    r = v[ACCEL_W-1] ? ACCEL_W'(-v) : ACCEL_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/posture_and_inactivity_monitor_core.sv]
// Top level of the posture and inactivity monitor.
// Depends on pim_pkg and pim_activity.
`default_nettype none

// Takes one three-axis accelerometer sample (signed milli-g) per request and
// returns one result per sample: posture class, motion flag, apnea flag,
// episode count and buzzer code. A sample is captured in an input register,
// evaluated combinationally against the running state (previous magnitude,
// still counter, apnea flag, episode count), and the result lands in an output
// register. One sample is accepted every clock cycle while the result side
// keeps up. The rate is set by the state update loop in pim_activity. When the
// output register is held by out_stall, the input register still fills once
// before in_stall rises. Configuration writes are always accepted (cfg_ready is
// tied high); unknown register indexes are ignored. Time is measured in samples,
// so still_limit = 500 is ten seconds at 50 Hz.
module posture_and_inactivity_monitor_core import pim_pkg::*; #(
  parameter int ACCEL_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // sample input
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ACCEL_W-1:0] in_accel_x,
  input  wire logic signed [ACCEL_W-1:0] in_accel_y,
  input  wire logic signed [ACCEL_W-1:0] in_accel_z,
  // result output
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic             [2:0]         out_posture,
  output logic                           out_moved,
  output logic                           out_apnea_active,
  output logic             [CNT_W-1:0]   out_episode_total,
  output logic             [1:0]         out_buzzer_mode,
  // register writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic        [1:0]         cfg_index,
  input  wire logic        [CNT_W-1:0]   cfg_data
);

  // Register reset values: 0.30 g, 0.05 g, 10000 ms at 50 Hz.
  localparam logic [THR_W-1:0] POSTURE_THR_RST = THR_W'(300);
  localparam logic [CNT_W-1:0] MOTION_THR_RST  = CNT_W'(50);
  localparam logic [CNT_W-1:0] STILL_LIMIT_RST = CNT_W'(500);

  // ---- configuration registers ----
  logic [THR_W-1:0] posture_thr_r;
  logic [CNT_W-1:0] motion_thr_r;
  logic [CNT_W-1:0] still_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posture_thr_r <= POSTURE_THR_RST;
      motion_thr_r  <= MOTION_THR_RST;
      still_limit_r <= STILL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSTURE_THR: posture_thr_r <= cfg_data[THR_W-1:0];
        CFG_MOTION_THR:  motion_thr_r  <= cfg_data;
        CFG_STILL_LIMIT: still_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- input register ----
  logic                      in_vld_r;
  logic signed [ACCEL_W-1:0] x_r, y_r, z_r;
  logic                      out_free;
  logic                      advance;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      x_r <= in_accel_x;
      y_r <= in_accel_y;
      z_r <= in_accel_z;
    end
  end

  // ---- posture: strict compares, fixed priority ----
  logic signed [ACCEL_W:0] thr_pos, thr_neg, y_ext, z_ext;
  posture_t                posture;

  always_comb begin
    thr_pos = (ACCEL_W+1)'($signed({2'b00, posture_thr_r}));
    thr_neg = -thr_pos;
    y_ext   = (ACCEL_W+1)'(y_r);
    z_ext   = (ACCEL_W+1)'(z_r);
    if (z_ext < thr_neg)      posture = POS_PRONE;
    else if (z_ext > thr_pos) posture = POS_SUPINE;
    else if (y_ext > thr_pos) posture = POS_LEFT;
    else if (y_ext < thr_neg) posture = POS_RIGHT;
    else                      posture = POS_MIDDLE;
  end

  // ---- motion / apnea state, updated as the sample moves to the output ----
  activity_t act;

  pim_activity #(
    .ACCEL_BITS (ACCEL_BITS)
  ) u_activity (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .x           (x_r),
    .y           (y_r),
    .z           (z_r),
    .motion_thr  (motion_thr_r),
    .still_limit (still_limit_r),
    .act         (act)
  );

  // Apnea tone overrides the prone tone.
  buzzer_t buzzer;

  always_comb begin
    if (act.apnea)                buzzer = BUZ_APNEA;
    else if (posture == POS_PRONE) buzzer = BUZ_PRONE;
    else                          buzzer = BUZ_SILENT;
  end

  // ---- output register ----
  logic             out_vld_r;
  posture_t         posture_r;
  logic             moved_r;
  logic             apnea_r;
  logic [CNT_W-1:0] episodes_r;
  buzzer_t          buzzer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      posture_r  <= posture;
      moved_r    <= act.moved;
      apnea_r    <= act.apnea;
      episodes_r <= act.episodes;
      buzzer_r   <= buzzer;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_posture       = posture_r;
  assign out_moved         = moved_r;
  assign out_apnea_active  = apnea_r;
  assign out_episode_total = episodes_r;
  assign out_buzzer_mode   = buzzer_r;

endmodule

`default_nettype wire

[hdl/pim_activity.sv]
// Motion detection and apnea tracking: magnitude, still counter, episode count.
// Depends on pim_pkg. State advances once per sample when en is high.
`default_nettype none

module pim_activity import pim_pkg::*; #(
  parameter int ACCEL_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic signed [ACCEL_W-1:0] x,
  input  wire logic signed [ACCEL_W-1:0] y,
  input  wire logic signed [ACCEL_W-1:0] z,
  input  wire logic        [CNT_W-1:0]   motion_thr,
  input  wire logic        [CNT_W-1:0]   still_limit,
  output activity_t                      act
);

  localparam int CMP_W  = (ACCEL_BITS > SUM_W) ? ACCEL_BITS : SUM_W;
  localparam int DIFF_W = (ACCEL_BITS > CNT_W) ? ACCEL_BITS : CNT_W;
  localparam logic [CMP_W-1:0] MAG_MAX = CMP_W'((64'd1 << ACCEL_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [ACCEL_BITS-1:0] prev_mag_r, prev_mag_nxt;
  logic [CNT_W-1:0]      still_r, still_nxt;
  logic                  apnea_r, apnea_nxt;
  logic [CNT_W-1:0]      episodes_r, episodes_nxt;

  logic [CMP_W-1:0]      sum;
  logic [ACCEL_BITS-1:0] mag;
  logic [ACCEL_BITS-1:0] diff;
  logic                  moved;

  always_comb begin
    sum = CMP_W'(SUM_W'(abs_accel(x)) + SUM_W'(abs_accel(y)) + SUM_W'(abs_accel(z)));
    mag = (sum > MAG_MAX) ? '1 : sum[ACCEL_BITS-1:0];
    diff = (mag >= prev_mag_r) ? (mag - prev_mag_r) : (prev_mag_r - mag);
    moved = DIFF_W'(diff) > DIFF_W'(motion_thr);
  end

  always_comb begin
    prev_mag_nxt = mag;
    still_nxt    = still_r;
    apnea_nxt    = apnea_r;
    episodes_nxt = episodes_r;
    if (moved) begin
      still_nxt = '0;
      apnea_nxt = 1'b0;
    end else if (still_r != CNT_MAX) begin
      still_nxt = still_r + 1'b1;
    end
    // New episode starts only on the rising edge of the flag.
    if (still_nxt > still_limit && !apnea_nxt) begin
      apnea_nxt = 1'b1;
      if (episodes_r != CNT_MAX) begin
        episodes_nxt = episodes_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r <= '0;
      still_r    <= '0;
      apnea_r    <= 1'b0;
      episodes_r <= '0;
    end else if (en) begin
      prev_mag_r <= prev_mag_nxt;
      still_r    <= still_nxt;
      apnea_r    <= apnea_nxt;
      episodes_r <= episodes_nxt;
    end
  end

  assign act.moved    = moved;
  assign act.apnea    = apnea_nxt;
  assign act.episodes = episodes_nxt;

endmodule

`default_nettype wire
